FILE: hdl/bdar_pkg.sv
// Package for the button debounce and auto-repeat core.
// Holds field widths, register indexes and register reset values.
// No dependencies.
package bdar_pkg;

  localparam int unsigned ButtonW   = 7;
  localparam int unsigned IntervalW = 10;
  localparam int unsigned AccelW    = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 10;

  typedef logic [ButtonW-1:0]   button_t;
  typedef logic [IntervalW-1:0] interval_t;
  typedef logic [AccelW-1:0]    accel_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxInterval = 2'd0,
    CfgAccelReload = 2'd1,
    CfgStep        = 2'd2,
    CfgMinInterval = 2'd3
  } cfg_idx_e;

  localparam interval_t MaxIntervalRst = 10'd400;
  localparam accel_t    AccelReloadRst = 8'd10;
  localparam interval_t StepRst        = 10'd100;
  localparam interval_t MinIntervalRst = 10'd100;

endpackage

FILE: hdl/button_debounce_autorepeat_core.sv
// Button debounce with typematic auto-repeat and repeat acceleration.
// Depends on bdar_pkg for widths, register indexes and reset values.
//
// Takes one sample of seven active-low button levels per item and returns one
// result item per sample: tuser is set when a change or repeat report is
// issued, and tdata then carries the debounced pressed bitmap (zero
// otherwise). A sustained rate of one item per clock cycle is reached while
// the result stream is not stalled. A sample is held in the input register,
// and a single pass over the debounce history and repeat counters between
// that register and the result register produces its result, which is
// offered from the result register. A stalled result holds off the input
// only once both registers are full. Configuration writes to the maximum
// interval take effect at the next unstable sample; the others also when the interval is shortened.
module button_debounce_autorepeat_core #(
  parameter int unsigned NDEBOUNCE = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Sample stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [6:0] raw_levels
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [6:0] pressed_map
  output logic                          m_axis_tuser,  // [0] report_flag
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [bdar_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bdar_pkg::CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  bdar_pkg::interval_t max_int_q, step_q, min_int_q;
  bdar_pkg::accel_t    accel_rld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_int_q   <= bdar_pkg::MaxIntervalRst;
      accel_rld_q <= bdar_pkg::AccelReloadRst;
      step_q      <= bdar_pkg::StepRst;
      min_int_q   <= bdar_pkg::MinIntervalRst;
    end else if (cfg_we_i) begin
      unique case (bdar_pkg::cfg_idx_e'(cfg_idx_i))
        bdar_pkg::CfgMaxInterval: max_int_q   <= cfg_data_i[bdar_pkg::IntervalW-1:0];
        bdar_pkg::CfgAccelReload: accel_rld_q <= cfg_data_i[bdar_pkg::AccelW-1:0];
        bdar_pkg::CfgStep:        step_q      <= cfg_data_i[bdar_pkg::IntervalW-1:0];
        bdar_pkg::CfgMinInterval: min_int_q   <= cfg_data_i[bdar_pkg::IntervalW-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic                s1_valid_q;
  bdar_pkg::button_t   s1_raw_q;
  logic                out_free, proc;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign proc          = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_raw_q <= s_axis_tdata[bdar_pkg::ButtonW-1:0];
    end
  end

  // Debounce history and repeat state.
  bdar_pkg::button_t   hist_q [NDEBOUNCE];
  bdar_pkg::button_t   last_q, last_d;
  bdar_pkg::interval_t timer_q, timer_d;
  bdar_pkg::interval_t int_q, int_d;
  bdar_pkg::accel_t    accel_q, accel_d;

  bdar_pkg::button_t   btn;
  logic                stable, expired, report_ev, flag_d;
  logic [NDEBOUNCE-1:0] match;
  logic signed [bdar_pkg::IntervalW:0] int_next;

  assign btn = ~s1_raw_q;

  always_comb begin
    for (int i = 0; i < NDEBOUNCE; i++) begin
      match[i] = (hist_q[i] == btn);
    end
  end

  assign stable    = &match;
  assign expired   = (timer_q <= bdar_pkg::interval_t'(1));
  assign report_ev = (btn != last_q) || expired;
  assign int_next  = $signed({1'b0, int_q}) - $signed({1'b0, step_q});

  always_comb begin
    last_d  = last_q;
    int_d   = int_q;
    accel_d = accel_q;
    flag_d  = 1'b0;
    timer_d = timer_q;
    if (!stable) begin
      int_d   = max_int_q;
      accel_d = accel_rld_q;
      timer_d = max_int_q;
    end else begin
      if (report_ev) begin
        if (expired) begin
          if (accel_q <= bdar_pkg::accel_t'(1)) begin
            // Counter runs out: reload it and shorten the interval.
            accel_d = accel_rld_q;
            if (int_next < $signed({1'b0, min_int_q})) begin
              int_d = min_int_q;
            end else begin
              int_d = int_next[bdar_pkg::IntervalW-1:0];
            end
          end else begin
            accel_d = accel_q - bdar_pkg::accel_t'(1);
          end
        end
        // A report of all released after all released stays silent.
        flag_d = (btn != '0) || (last_q != '0);
        last_d = btn;
      end
      if (expired) begin
        timer_d = int_d;
      end else begin
        timer_d = timer_q - bdar_pkg::interval_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NDEBOUNCE; i++) begin
        hist_q[i] <= '0;
      end
      last_q  <= '0;
      timer_q <= '0;
      int_q   <= bdar_pkg::MaxIntervalRst;
      accel_q <= bdar_pkg::AccelReloadRst;
    end else if (proc) begin
      for (int i = 0; i < NDEBOUNCE - 1; i++) begin
        hist_q[i] <= hist_q[i+1];
      end
      hist_q[NDEBOUNCE-1] <= btn;
      last_q  <= last_d;
      timer_q <= timer_d;
      int_q   <= int_d;
      accel_q <= accel_d;
    end
  end

  // Result register.
  logic              m_flag_q;
  bdar_pkg::button_t m_map_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      m_flag_q <= flag_d;
      m_map_q  <= flag_d ? btn : '0;
    end
  end

  assign m_axis_tuser = m_flag_q;
  assign m_axis_tdata = {1'b0, m_map_q};

`ifndef NO_ASSERTIONS
  // An unstable sample leaves timer and interval both at the starting value.
  a_unstable_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !stable) |=> (timer_q == int_q))
    else $error("timer and interval differ after an unstable sample");

  // A silent result never carries a bitmap.
  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("bitmap present without a report");

  // A reported bitmap becomes the last reported state.
  a_report_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && flag_d) |=> (last_q == m_map_q))
    else $error("last reported bitmap does not match the report");

  // An item held in the input register is not dropped while the output stalls.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_raw_q)))
    else $error("input item lost during an output stall");
`endif

endmodule
